// File: rtl/alpha_outline_painter_macros.svh
// Assertion macros used by the outline painter RTL.
`ifndef ALPHA_OUTLINE_PAINTER_MACROS_SVH
`define ALPHA_OUTLINE_PAINTER_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define AOP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define AOP_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define AOP_ASSERT(name, prop, msg)
`define AOP_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// File: rtl/aop_pkg.sv
// Shared constants and helper functions of the outline painter.
`timescale 1ns / 1ps
package aop_pkg;

   localparam int PIXEL_INDEX_W = 16;
   localparam int CHANNEL_W     = 8;
   localparam int COUNT_W       = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 9;

   // Command codes.
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_OUTLINE = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_RED   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_GREEN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_BLUE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd4;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 9'd256;

   localparam logic [CHANNEL_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHANNEL_W-1:0] ALPHA_CLEAR  = 8'h00;

   // Neighbor visiting order: up, right, left, down, then the diagonals.
   localparam logic [2:0] NB_LAST = 3'd7;

   function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd0, 3'd3:       d = 2'sd0;
         3'd1, 3'd5, 3'd7: d = 2'sd1;
         default:          d = -2'sd1;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd1, 3'd2:       d = 2'sd0;
         3'd3, 3'd6, 3'd7: d = 2'sd1;
         default:          d = -2'sd1;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/aop_req_if.sv
// Command channel of the outline painter.
`timescale 1ns / 1ps
interface aop_req_if;
   import aop_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic [PIXEL_INDEX_W-1:0] pixel_index;
   logic [CHANNEL_W-1:0]     pixel_red;
   logic [CHANNEL_W-1:0]     pixel_green;
   logic [CHANNEL_W-1:0]     pixel_blue;
   logic [CHANNEL_W-1:0]     pixel_alpha;

   modport source (output valid, command, pixel_index, pixel_red, pixel_green,
                   pixel_blue, pixel_alpha, input ready);
   modport sink (input valid, command, pixel_index, pixel_red, pixel_green,
                 pixel_blue, pixel_alpha, output ready);
endinterface

// File: rtl/aop_rsp_if.sv
// Result channel of the outline painter.
`timescale 1ns / 1ps
interface aop_rsp_if;
   import aop_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] read_red;
   logic [CHANNEL_W-1:0] read_green;
   logic [CHANNEL_W-1:0] read_blue;
   logic [CHANNEL_W-1:0] read_alpha;
   logic [COUNT_W-1:0]   painted_count;

   modport source (output valid, read_red, read_green, read_blue, read_alpha,
                   painted_count, input ready);
   modport sink (input valid, read_red, read_green, read_blue, read_alpha,
                 painted_count, output ready);
endinterface

// File: rtl/alpha_outline_painter.sv
// Top level of the outline painter: pixel store, sequencer and registers.
`timescale 1ns / 1ps
`include "alpha_outline_painter_macros.svh"
// The block keeps an RGBA image of up to MAX_WIDTH by MAX_HEIGHT pixels in one
// synchronous RAM, one 32-bit word per pixel (red in the low byte, alpha in the
// high byte), addressed by the linear index row times width plus column. Every
// item gives exactly one result item. A write item stores one pixel when its
// index lies inside the store. A read item returns the stored pixel through the
// RAM read register and then the result register. An outline item splits its
// index into row and column with a bit-serial divider, then walks the eight
// neighbors; each neighbor inside the image is read from the RAM in one state
// and checked in the next, where a transparent pixel is painted, and a neighbor
// outside the image is skipped in the read state. The block works on one item at
// a time; while a finished result waits in the output register no new item is
// taken, and the next item is accepted at the earliest in the cycle in which the
// waiting result is taken. The store has no reset: a pixel must be written
// before it is read, directly or as an outline neighbor. Border color and image
// size are written through the register port; the user must do so only while
// the block is idle, which the block itself does not enforce. Width and height
// saturate to 1 .. MAX_WIDTH and 1 .. MAX_HEIGHT.
module alpha_outline_painter #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   aop_req_if.sink                          req_chan,
   aop_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [aop_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [aop_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import aop_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int WW          = $clog2(MAX_WIDTH + 1);
   localparam int HW          = $clog2(MAX_HEIGHT + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_OUT,
      S_DIV,
      S_NB_RD,
      S_NB_CHK,
      S_DONE
   } state_type;

   // Configuration registers.
   logic [CHANNEL_W-1:0]  border_red_ff, border_green_ff, border_blue_ff;
   logic [CSR_DATA_W-1:0] image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         border_red_ff   <= '0;
         border_green_ff <= '0;
         border_blue_ff  <= '0;
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BORDER_RED:   border_red_ff   <= csr_write_data[CHANNEL_W-1:0];
            CSR_BORDER_GREEN: border_green_ff <= csr_write_data[CHANNEL_W-1:0];
            CSR_BORDER_BLUE:  border_blue_ff  <= csr_write_data[CHANNEL_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective image size, saturated to the supported range.
   logic [WW-1:0] width_eff;
   logic [HW-1:0] height_eff;
   logic [31:0]   width_wide, height_wide;

   always_comb begin
      width_wide  = 32'(image_width_ff);
      height_wide = 32'(image_height_ff);
      if (width_wide == 32'd0) begin
         width_wide = 32'd1;
      end else if (width_wide > 32'(MAX_WIDTH)) begin
         width_wide = 32'(MAX_WIDTH);
      end
      if (height_wide == 32'd0) begin
         height_wide = 32'd1;
      end else if (height_wide > 32'(MAX_HEIGHT)) begin
         height_wide = 32'(MAX_HEIGHT);
      end
      width_eff  = width_wide[WW-1:0];
      height_eff = height_wide[HW-1:0];
   end

   // Sequencer state and registered result.
   state_type                state_ff, state_in;
   logic [2:0]               k_ff, k_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [PIXEL_INDEX_W-1:0] idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_word_ff, rsp_word_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // Pixel store and divider connections.
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [31:0]       mem_wdata, mem_rdata;
   logic              div_start, div_done;
   logic [PIXEL_INDEX_W-1:0] row;
   logic [WW-1:0]     col;

   aop_ram #(
      .WIDTH (32),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (mem_waddr),
      .write_data   (mem_wdata),
      .read_enable  (mem_re),
      .read_addr    (mem_raddr),
      .read_data    (mem_rdata)
   );

   aop_divider #(
      .DIVIDEND_W (PIXEL_INDEX_W),
      .DIVISOR_W  (WW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_chan.pixel_index),
      .divisor   (width_eff),
      .done      (div_done),
      .quotient  (row),
      .remainder (col)
   );

   logic accept, slot_free, idx_in_store;
   logic [31:0] idx_wide;

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && slot_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign idx_wide       = 32'(req_chan.pixel_index);
   assign idx_in_store   = idx_wide < 32'(STORE_DEPTH);

   // Neighbor under test: bounds check and address idx + dr * width + dc.
   // The address only matters when the neighbor is inside the image, where
   // it always falls inside the store.
   logic signed [1:0] dc, dr;
   logic        col_ok, row_ok, nb_valid;
   logic [31:0] row_wide, col_wide, w_wide, h_wide;
   logic [31:0] dr_term, dc_term, nb_sum;
   logic [AW-1:0] nb_addr;

   always_comb begin
      dc       = nb_dc(k_ff);
      dr       = nb_dr(k_ff);
      row_wide = 32'(row);
      col_wide = 32'(col);
      w_wide   = 32'(width_eff);
      h_wide   = 32'(height_eff);
      if (dc == 2'sd1) begin
         col_ok = (col_wide + 32'd1) < w_wide;
      end else if (dc == -2'sd1) begin
         col_ok = col_wide != 32'd0;
      end else begin
         col_ok = 1'b1;
      end
      if (dr == 2'sd1) begin
         row_ok = (row_wide + 32'd1) < h_wide;
      end else if (dr == -2'sd1) begin
         row_ok = (row_wide != 32'd0) && ((row_wide - 32'd1) < h_wide);
      end else begin
         row_ok = row_wide < h_wide;
      end
      nb_valid = col_ok && row_ok;
      if (dr == 2'sd1) begin
         dr_term = w_wide;
      end else if (dr == -2'sd1) begin
         dr_term = 32'd0 - w_wide;
      end else begin
         dr_term = 32'd0;
      end
      dc_term = {{30{dc[1]}}, dc};
      nb_sum  = 32'(idx_ff) + dr_term + dc_term;
      nb_addr = nb_sum[AW-1:0];
   end

   logic [31:0] paint_word, write_word;

   assign paint_word = {ALPHA_OPAQUE, border_blue_ff, border_green_ff, border_red_ff};
   assign write_word = {req_chan.pixel_alpha, req_chan.pixel_blue,
                        req_chan.pixel_green, req_chan.pixel_red};

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_wide[AW-1:0];
      mem_wdata    = write_word;
      mem_re       = 1'b0;
      mem_raddr    = idx_wide[AW-1:0];
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Writes, unused codes and reads beyond the store finish at once.
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               rsp_count_in = '0;
               case (req_chan.command)
                  CMD_WRITE: begin
                     mem_we = idx_in_store;
                  end
                  CMD_READ: begin
                     if (idx_in_store) begin
                        mem_re       = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_RD_OUT;
                     end
                  end
                  CMD_OUTLINE: begin
                     div_start    = 1'b1;
                     idx_in       = req_chan.pixel_index;
                     k_in         = '0;
                     count_in     = '0;
                     rsp_valid_in = 1'b0;
                     state_in     = S_DIV;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = mem_rdata;
               rsp_count_in = '0;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            if (nb_valid) begin
               mem_re    = 1'b1;
               mem_raddr = nb_addr;
               state_in  = S_NB_CHK;
            end else if (k_ff == NB_LAST) begin
               state_in = S_DONE;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_NB_CHK: begin
            // Neighbors are distinct pixels, so a paint never feeds a later read
            // of the same walk; the write lands before the next read anyway.
            if (mem_rdata[31:24] == ALPHA_CLEAR) begin
               mem_we    = 1'b1;
               mem_waddr = nb_addr;
               mem_wdata = paint_word;
               count_in  = count_ff + 1'b1;
            end
            if (k_ff == NB_LAST) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = S_NB_RD;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_red      = rsp_word_ff[7:0];
   assign rsp_chan.read_green    = rsp_word_ff[15:8];
   assign rsp_chan.read_blue     = rsp_word_ff[23:16];
   assign rsp_chan.read_alpha    = rsp_word_ff[31:24];
   assign rsp_chan.painted_count = rsp_count_ff;

   // An accepted outline item always starts the divider phase.
   `AOP_ASSERT(a_outline_enters_div, (accept && (req_chan.command == CMD_OUTLINE)) |=> (state_ff == S_DIV), "outline item did not start the divider")
   // The divider only finishes while the sequencer waits for it.
   `AOP_ASSERT(a_div_done_in_div, div_done |-> (state_ff == S_DIV), "divider finished outside its phase")
   // A new result only appears as the sequencer returns to idle.
   `AOP_ASSERT(a_result_at_idle, $rose(rsp_valid_ff) |-> (state_ff == S_IDLE), "result loaded while still busy")
   // At most eight neighbors can be painted.
   `AOP_ASSERT_NEVER(a_count_bound, count_ff > COUNT_W'(8), "painted count above eight")
endmodule

// File: rtl/aop_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
module aop_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

// File: rtl/aop_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module aop_divider #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  r_ff, r_in;
   logic [DIVISOR_W-1:0]  d_ff, d_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      shifted = {r_ff, q_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, d_ff};
      if (start) begin
         cnt_in = CNT_W'(DIVIDEND_W);
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (cnt_ff != '0) begin
         // The partial remainder stays below the divisor whenever the divisor is nonzero.
         if (shifted >= {1'b0, d_ff}) begin
            r_in = diff[DIVISOR_W-1:0];
            q_in = {q_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            r_in = shifted[DIVISOR_W-1:0];
            q_in = {q_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule
